// File: rtl/cst_pkg.sv
// Shared types and constants for the counted slot table.
// Holds payload structs, operation codes, controller states and command bundle.
// No dependencies.
`default_nettype none

package cst_pkg;

    localparam int KEY_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 16;
    localparam int KIND_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_KEY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_CNT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   item_key;
        logic [SLOT_W-1:0]  slot_number;
        logic [COUNT_W-1:0] new_count;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot_used;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] count_out;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic look;   // register match and free vectors
        logic exec;   // apply update, load result register
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/cst_datapath.sv
// Datapath of the counted slot table: slot registers, match vectors, update.
// Depends on cst_pkg; driven by commands from cst_ctrl.
`default_nettype none

module cst_datapath
    import cst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ID_BITS   = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_cmd   i_cmd,
    input  wire t_in_item  i_item,
    output t_out_item      o_item
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [ID_BITS-1:0] r_key_tab [NUM_SLOTS];
    logic [COUNT_W-1:0] r_cnt_tab [NUM_SLOTS];

    logic [KIND_W-1:0]  r_kind;
    logic [ID_BITS-1:0] r_key;
    logic [SLOT_W-1:0]  r_sn;
    logic [COUNT_W-1:0] r_cnt;
    logic [NUM_SLOTS-1:0] r_match;
    logic [NUM_SLOTS-1:0] r_free;
    t_out_item          r_out;

    logic [ID_BITS-1:0] n_key;
    logic [IDX_W-1:0]   sn_idx;
    logic               sn_ok;
    logic               match_hit, free_hit;
    logic [IDX_W-1:0]   match_idx, free_idx;

    logic               ok, we;
    logic [IDX_W-1:0]   idx;
    logic [ID_BITS-1:0] wkey;
    logic [COUNT_W-1:0] wcnt, cur_cnt, dec_cnt;
    logic [ID_BITS-1:0] cur_key;
    t_out_item          n_out;

    // Narrow or widen the incoming key to ID_BITS
    always_comb begin
        n_key = '0;
        for (int b = 0; b < ID_BITS; b++) begin
            if (b < KEY_W) n_key[b] = i_item.item_key[b % KEY_W];
        end
    end

    // Slot number as a table index
    always_comb begin
        sn_idx = '0;
        for (int b = 0; b < IDX_W; b++) begin
            if (b < SLOT_W) sn_idx[b] = r_sn[b % SLOT_W];
        end
        sn_ok = (int'(r_sn) < NUM_SLOTS);
    end

    // Lowest set bit of the registered vectors
    always_comb begin
        match_hit = 1'b0;
        free_hit  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                match_hit = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (r_free[i]) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        ok      = 1'b0;
        we      = 1'b0;
        idx     = match_idx;
        unique case (r_kind)
            KIND_ADD: begin
                ok  = match_hit | free_hit;
                we  = ok;
                idx = match_hit ? match_idx : free_idx;
            end
            KIND_REMOVE: begin
                ok  = match_hit;
                we  = match_hit;
                idx = match_idx;
            end
            KIND_SET_KEY, KIND_SET_CNT: begin
                ok  = sn_ok;
                we  = sn_ok;
                idx = sn_idx;
            end
            KIND_READ: begin
                ok  = sn_ok;
                idx = sn_idx;
            end
            default: begin
                ok  = 1'b0;
            end
        endcase

        cur_key = r_key_tab[idx];
        cur_cnt = r_cnt_tab[idx];
        dec_cnt = (cur_cnt != '0) ? cur_cnt - COUNT_W'(1) : '0;
        wkey    = cur_key;
        wcnt    = cur_cnt;
        unique case (r_kind)
            KIND_ADD: begin
                if (match_hit) begin
                    wcnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1);
                end else begin
                    wkey = r_key;
                    wcnt = COUNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                wcnt = dec_cnt;
                if (dec_cnt == '0) wkey = '0;
            end
            KIND_SET_KEY: begin
                wkey = r_key;
                wcnt = COUNT_W'(1);
            end
            KIND_SET_CNT: begin
                wcnt = r_cnt;
            end
            default: begin
                wkey = cur_key;
            end
        endcase

        n_out = '0;
        if (ok) begin
            n_out.ok = 1'b1;
            for (int b = 0; b < SLOT_W; b++) begin
                if (b < IDX_W) n_out.slot_used[b] = idx[b % IDX_W];
            end
            for (int b = 0; b < KEY_W; b++) begin
                if (b < ID_BITS) n_out.key_out[b] = wkey[b % ID_BITS];
            end
            n_out.count_out = wcnt;
        end
    end

    // Table registers, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_key_tab[i] <= '0;
                r_cnt_tab[i] <= '0;
            end
        end else if (i_cmd.exec && we) begin
            r_key_tab[idx] <= wkey;
            r_cnt_tab[idx] <= wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_key  <= n_key;
            r_sn   <= i_item.slot_number;
            r_cnt  <= i_item.new_count;
        end
        if (i_cmd.look) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_match[i] <= (r_key_tab[i] == r_key);
                r_free[i]  <= (r_cnt_tab[i] == '0);
            end
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

// File: rtl/cst_ctrl.sv
// Controller of the counted slot table: sequencing and output handshake.
// Depends on cst_pkg; issues commands to cst_datapath.
`default_nettype none

module cst_ctrl
    import cst_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                // Hold until the result register can take the new item
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_LOOK;
                    end else begin
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.exec)       n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/counted_slot_table_unit.sv
// Each accepted item is captured, then a lookup cycle registers the match and
//   free vectors, and an execute cycle updates the slot, registers the result
//   and takes the next item in that same cycle.
// A stalled result holds the execute cycle until the output register frees.
// Reset (synchronous, active low) clears every slot identifier and count.
`default_nettype none

module counted_slot_table_unit
    import cst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ID_BITS   = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // input item channel
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    // result item channel
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    t_dp_cmd cmd;

    // Controller: accepts an item, sequences lookup and execute, owns the
    // output valid flag; hold the execute cycle while a result waits.
    cst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Datapath: slot table, parallel match and free vectors, lowest-slot
    // pick, write back and the result register.
    cst_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_in_item),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire

// File: rtl/cst_checker.sv
// Port-level checker for counted_slot_table_unit, with its bind statement.
// Depends on cst_pkg.
`default_nettype none

module cst_checker
    import cst_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // A failed operation reports all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.ok |->
            o_out_item.slot_used == '0 && o_out_item.key_out == '0 &&
            o_out_item.count_out == '0)
        else $error("failed result carries data");

    // Lookup cycle follows every accept
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready during lookup cycle");

    // The lookup cycle never raises a result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 (!o_out_valid || i_out_ready) |=> !o_out_valid)
        else $error("result appeared during lookup cycle");

endmodule

bind counted_slot_table_unit cst_checker u_cst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for counted_slot_table_unit: directed and random table operations,
// predicted in the bench and compared field by field. Depends on cst_pkg and the block.

module tb;
    import cst_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int ID_BITS      = 16;
    localparam int POOL_SIZE    = 24;
    localparam int PHASES       = 17;
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRINT_CAP    = 200;

    // kinds the block must ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MASK =
        (ID_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << ID_BITS) - 1);

    typedef struct {
        t_in_item  op;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // shadow copy of the slot table
    logic [KEY_W-1:0]   key_tbl [NUM_SLOTS];
    logic [COUNT_W-1:0] cnt_tbl [NUM_SLOTS];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    t_out_item        pending_results [$];
    t_stim_row        dir_rows [$];

    int  fault_cnt = 0;
    int  cycle_cnt = 0;
    bit  burst     = 1'b0;  // both sides run without gaps
    bit  hold_long = 1'b0;  // ask the receiver for one long stall

    counted_slot_table_unit #(
        .NUM_SLOTS(NUM_SLOTS),
        .ID_BITS  (ID_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("[counted_slot_table_unit] ERROR");
            $finish;
        end
    end

    // Lowest slot holding this identifier, or -1.
    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (key_tbl[i] == k)
                return i;
        return -1;
    endfunction

    // Apply one operation to the shadow table and return the result it yields.
    function automatic t_out_item apply_slot_op(t_in_item op);
        t_out_item        r;
        logic [KEY_W-1:0] k;
        int               hit;
        r   = '0;
        k   = op.item_key & KEY_MASK;
        hit = -1;
        case (op.kind)
            KIND_ADD: begin
                hit = find_key(k);
                if (hit >= 0) begin
                    // saturate rather than wrap
                    if (cnt_tbl[hit] != COUNT_MAX)
                        cnt_tbl[hit] = cnt_tbl[hit] + COUNT_W'(1);
                end else begin
                    // claim the lowest slot with a zero count
                    for (int i = 0; i < NUM_SLOTS && hit < 0; i++)
                        if (cnt_tbl[i] == '0)
                            hit = i;
                    if (hit >= 0) begin
                        key_tbl[hit] = k;
                        cnt_tbl[hit] = COUNT_W'(1);
                    end
                end
            end
            KIND_REMOVE: begin
                hit = find_key(k);
                if (hit >= 0) begin
                    if (cnt_tbl[hit] != '0)
                        cnt_tbl[hit] = cnt_tbl[hit] - COUNT_W'(1);
                    if (cnt_tbl[hit] == '0)
                        key_tbl[hit] = '0;
                end
            end
            KIND_SET_KEY, KIND_SET_CNT, KIND_READ: begin
                if (int'(op.slot_number) < NUM_SLOTS) begin
                    hit = int'(op.slot_number);
                    if (op.kind == KIND_SET_KEY) begin
                        key_tbl[hit] = k;
                        cnt_tbl[hit] = COUNT_W'(1);
                    end else if (op.kind == KIND_SET_CNT) begin
                        cnt_tbl[hit] = op.new_count;
                    end
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            r.ok        = 1'b1;
            r.slot_used = hit[SLOT_W-1:0];
            r.key_out   = key_tbl[hit];
            r.count_out = cnt_tbl[hit];
        end
        return r;
    endfunction

    function automatic t_stim_row mk_row(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                         logic [SLOT_W-1:0] slot, logic [COUNT_W-1:0] cnt,
                                         bit typed = 1'b0, t_out_item want = '0);
        t_stim_row row;
        row.op.kind        = kind;
        row.op.item_key    = key;
        row.op.slot_number = slot;
        row.op.new_count   = cnt;
        row.typed          = typed;
        row.want           = want;
        return row;
    endfunction

    // Random operation; add_pct biases the mix toward filling or draining.
    function automatic t_in_item rand_slot_op(int add_pct);
        t_in_item op;
        int       roll;
        op.kind        = KIND_READ;
        op.item_key    = KEY_W'($urandom);
        op.slot_number = SLOT_W'($urandom);
        op.new_count   = COUNT_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            op.kind = KIND_ADD;
        else if (roll < 75)
            op.kind = KIND_REMOVE;
        else if (roll < 82)
            op.kind = KIND_SET_KEY;
        else if (roll < 89)
            op.kind = KIND_SET_CNT;
        else if (roll < 96)
            op.kind = KIND_READ;
        else begin
            case ($urandom_range(0, 2))
                0:       op.kind = KIND_SPARE_A;
                1:       op.kind = KIND_SPARE_B;
                default: op.kind = KIND_SPARE_C;
            endcase
        end
        // mostly reuse a small key set so adds and removes meet
        if ($urandom_range(0, 99) < 85)
            op.item_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 50)
            op.new_count = COUNT_W'($urandom_range(0, 3));
        else if (roll < 60)
            op.new_count = COUNT_MAX - COUNT_W'($urandom_range(0, 1));
        return op;
    endfunction

    // Offer one item after a random gap, hold it until accepted, then predict.
    task automatic send_op(t_in_item op, bit typed, t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = burst ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_slot_op(op);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid so the accepted item is not offered again, then wait.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fault_cnt++;
            if (fault_cnt <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    // Receiver: stall at random, once for a long stretch, and check each result item.
    initial begin
        int        stall;
        t_out_item want;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_long) begin
                stall     = LONG_HOLD;
                hold_long = 1'b0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 11);
            end
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= PRINT_CAP)
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, o_out_item);
            end else begin
                want = pending_results.pop_front();
                check_field("ok", 32'(want.ok), 32'(o_out_item.ok));
                check_field("slot_used", 32'(want.slot_used), 32'(o_out_item.slot_used));
                check_field("key_out", 32'(want.key_out), 32'(o_out_item.key_out));
                check_field("count_out", 32'(want.count_out), 32'(o_out_item.count_out));
            end
        end
    end

    // Sender and run control.
    initial begin
        int add_pct;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            key_tbl[i] = '0;
            cnt_tbl[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom_range(1, 16'hFFFE));

        // Directed rows; typed expectations only where the value is obvious.
        // Fresh table reads as empty at both ends.
        dir_rows.push_back(mk_row(KIND_READ, 16'h0000, 4'd0, 16'h0000, 1'b1,
                                  t_out_item'({1'b1, 4'd0, 16'h0000, 16'h0000})));
        dir_rows.push_back(mk_row(KIND_READ, 16'hFFFF, 4'd15, 16'hFFFF, 1'b1,
                                  t_out_item'({1'b1, 4'd15, 16'h0000, 16'h0000})));
        // Remove of an absent key fails with an all-zero result.
        dir_rows.push_back(mk_row(KIND_REMOVE, 16'h1234, 4'd9, 16'h00FF, 1'b1, '0));
        // Unknown kinds do nothing.
        dir_rows.push_back(mk_row(KIND_SPARE_A, 16'h0000, 4'd0, 16'h0000, 1'b1, '0));
        dir_rows.push_back(mk_row(KIND_SPARE_B, 16'hA5A5, 4'd5, 16'h5A5A, 1'b1, '0));
        dir_rows.push_back(mk_row(KIND_SPARE_C, 16'hFFFF, 4'd15, 16'hFFFF, 1'b1, '0));
        // Key zero matches the empty slot 0.
        dir_rows.push_back(mk_row(KIND_ADD, 16'h0000, 4'd3, 16'h0000, 1'b1,
                                  t_out_item'({1'b1, 4'd0, 16'h0000, 16'h0001})));
        dir_rows.push_back(mk_row(KIND_ADD, 16'hFFFF, 4'd0, 16'h0000));
        // Drive slot 1 to the ceiling, then saturate.
        dir_rows.push_back(mk_row(KIND_SET_CNT, 16'h0000, 4'd1, 16'hFFFE));
        dir_rows.push_back(mk_row(KIND_ADD, 16'hFFFF, 4'd0, 16'h0000));
        dir_rows.push_back(mk_row(KIND_ADD, 16'hFFFF, 4'd0, 16'h0000, 1'b1,
                                  t_out_item'({1'b1, 4'd1, 16'hFFFF, 16'hFFFF})));
        // Remove from a zero count still succeeds and clears the key.
        dir_rows.push_back(mk_row(KIND_SET_KEY, 16'hABCD, 4'd15, 16'h1111));
        dir_rows.push_back(mk_row(KIND_SET_CNT, 16'h2222, 4'd15, 16'h0000));
        dir_rows.push_back(mk_row(KIND_READ, 16'h3333, 4'd15, 16'h4444));
        dir_rows.push_back(mk_row(KIND_REMOVE, 16'hABCD, 4'd0, 16'h0000, 1'b1,
                                  t_out_item'({1'b1, 4'd15, 16'h0000, 16'h0000})));
        // Zero count keeps the key but frees the slot; a match still wins.
        dir_rows.push_back(mk_row(KIND_SET_KEY, 16'h5555, 4'd7, 16'h0000));
        dir_rows.push_back(mk_row(KIND_SET_CNT, 16'h0000, 4'd7, 16'h0000));
        dir_rows.push_back(mk_row(KIND_ADD, 16'h9999, 4'd0, 16'h0000));
        dir_rows.push_back(mk_row(KIND_ADD, 16'h5555, 4'd0, 16'h0000));
        // Key zero removal, then removal at zero on the same slot.
        dir_rows.push_back(mk_row(KIND_REMOVE, 16'h0000, 4'd0, 16'h0000));
        dir_rows.push_back(mk_row(KIND_REMOVE, 16'h0000, 4'd0, 16'h0000, 1'b1,
                                  t_out_item'({1'b1, 4'd0, 16'h0000, 16'h0000})));
        dir_rows.push_back(mk_row(KIND_SET_CNT, 16'h0000, 4'd0, 16'hFFFF));
        dir_rows.push_back(mk_row(KIND_ADD, 16'h0000, 4'd0, 16'h0000));

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);

        // Random phases alternate between filling and draining the table.
        for (int ph = 0; ph < PHASES; ph++) begin
            burst   = ($urandom_range(0, 3) == 0);
            add_pct = (ph % 2 == 0) ? 70 : $urandom_range(20, 45);
            if (ph == 3)
                hold_long = 1'b1;   // receiver stalls, input backs up
            if (ph == 6)
                wait_drained();     // pause until every result is back
            repeat (PHASE_ITEMS)
                send_op(rand_slot_op(add_pct), 1'b0, '0);
        end

        // Drop valid, let the results drain, then idle before the verdict.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_cnt == 0)
            $display("[counted_slot_table_unit] OK");
        else
            $display("[counted_slot_table_unit] ERROR");
        $finish;
    end

endmodule
